FILE: hdl/ubds_pkg.sv
package ubds_pkg;

    // Field widths
    localparam int BAUD_W = 23;
    localparam int CLK_W  = 27;
    localparam int OSR_W  = 6;
    localparam int ERR_W  = 42;

    // Oversampling range, one lane per ratio
    localparam int OSR_MIN = 4;
    localparam int OSR_MAX = 32;
    localparam int NUM_OSR = OSR_MAX - OSR_MIN + 1;
    localparam int TREE_N  = 32;

    // baud * osr stays below 2^28; 2*clock + den below 2^29
    localparam int DEN_W = BAUD_W + 5;
    localparam int NUM_W = DEN_W + 1;

    localparam logic [CLK_W-1:0] CLOCK_RESET = 27'd24000000;
    localparam logic [ERR_W-1:0] ERR_MAX     = '1;

    // Ratio handled by a lane
    function automatic logic [OSR_W-1:0] osr_of(input int lane);
        osr_of = OSR_W'(OSR_MIN + lane);
    endfunction

endpackage

FILE: hdl/ubds_prep.sv
module ubds_prep
    import ubds_pkg::*;
#(
    parameter int MAX_DIVISOR = 8191
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [BAUD_W-1:0]                    baud,
    input  logic [CLK_W-1:0]                     clock,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [NUM_OSR-1:0][NUM_W-1:0]        rem,
    output logic [NUM_OSR-1:0][NUM_W-1:0]        dvs,
    output logic [NUM_OSR-1:0][DEN_W-1:0]        den,
    output logic [NUM_OSR-1:0]                   sat
);

    localparam int QW = $clog2(MAX_DIVISOR + 1);
    localparam int LW = NUM_W + QW + 1;

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          rdy1;
    logic                          rdy2;
    logic [NUM_OSR-1:0][DEN_W-1:0] den1_reg;
    logic [NUM_OSR-1:0][DEN_W-1:0] den1_next;
    logic [NUM_OSR-1:0][NUM_W-1:0] rem_reg;
    logic [NUM_OSR-1:0][NUM_W-1:0] rem_next;
    logic [NUM_OSR-1:0][NUM_W-1:0] dvs_reg;
    logic [NUM_OSR-1:0][NUM_W-1:0] dvs_next;
    logic [NUM_OSR-1:0][DEN_W-1:0] den2_reg;
    logic [NUM_OSR-1:0]            sat_reg;
    logic [NUM_OSR-1:0]            sat_next;

    // Stall chain
    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: den = baud * osr per lane
    always_comb
    begin
        for (int k = 0; k < NUM_OSR; k++)
        begin
            den1_next[k] = DEN_W'(DEN_W'(baud) * DEN_W'(osr_of(k)));
        end
    end

    // Stage 2: rounding numerator, doubled divisor, clamp check
    always_comb
    begin
        for (int k = 0; k < NUM_OSR; k++)
        begin
            rem_next[k] = NUM_W'({clock, 1'b0}) + NUM_W'(den1_reg[k]);
            dvs_next[k] = {den1_reg[k], 1'b0};
            sat_next[k] = LW'(rem_next[k]) >= (LW'(MAX_DIVISOR + 1) * LW'(dvs_next[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            den1_reg <= den1_next;
        end
        if (v1_reg && rdy2)
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            den2_reg <= den1_reg;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = v2_reg;
    assign rem       = rem_reg;
    assign dvs       = dvs_reg;
    assign den       = den2_reg;
    assign sat       = sat_reg;

endmodule

FILE: hdl/ubds_div_step.sv
module ubds_div_step
    import ubds_pkg::*;
#(
    parameter int MAX_DIVISOR = 8191,
    parameter int BIT         = 0
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [NUM_OSR-1:0][NUM_W-1:0]                rem_in,
    input  logic [NUM_OSR-1:0][NUM_W-1:0]                dvs_in,
    input  logic [NUM_OSR-1:0][DEN_W-1:0]                den_in,
    input  logic [NUM_OSR-1:0]                           sat_in,
    input  logic [NUM_OSR-1:0][$clog2(MAX_DIVISOR+1)-1:0] q_in,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [NUM_OSR-1:0][NUM_W-1:0]                rem_out,
    output logic [NUM_OSR-1:0][NUM_W-1:0]                dvs_out,
    output logic [NUM_OSR-1:0][DEN_W-1:0]                den_out,
    output logic [NUM_OSR-1:0]                           sat_out,
    output logic [NUM_OSR-1:0][$clog2(MAX_DIVISOR+1)-1:0] q_out
);

    localparam int QW = $clog2(MAX_DIVISOR + 1);
    localparam int DW = NUM_W + QW;

    logic                          valid_reg;
    logic [NUM_OSR-1:0][NUM_W-1:0] rem_reg;
    logic [NUM_OSR-1:0][NUM_W-1:0] rem_next;
    logic [NUM_OSR-1:0][NUM_W-1:0] dvs_reg;
    logic [NUM_OSR-1:0][DEN_W-1:0] den_reg;
    logic [NUM_OSR-1:0]            sat_reg;
    logic [NUM_OSR-1:0][QW-1:0]    q_reg;
    logic [NUM_OSR-1:0][QW-1:0]    q_next;

    assign in_ready = !valid_reg || out_ready;

    // One restoring step: try divisor shifted to this quotient bit
    always_comb
    begin
        logic [DW-1:0] dsh;
        logic          ge;
        for (int k = 0; k < NUM_OSR; k++)
        begin
            dsh         = DW'(dvs_in[k]) << BIT;
            ge          = DW'(rem_in[k]) >= dsh;
            rem_next[k] = ge ? (rem_in[k] - dsh[NUM_W-1:0]) : rem_in[k];
            q_next[k]   = q_in[k];
            q_next[k][BIT] = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_in;
            den_reg <= den_in;
            sat_reg <= sat_in;
            q_reg   <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign dvs_out   = dvs_reg;
    assign den_out   = den_reg;
    assign sat_out   = sat_reg;
    assign q_out     = q_reg;

endmodule

FILE: hdl/ubds_err.sv
module ubds_err
    import ubds_pkg::*;
#(
    parameter int MAX_DIVISOR = 8191
)
(
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  logic [NUM_OSR-1:0][$clog2(MAX_DIVISOR+1)-1:0]       q,
    input  logic [NUM_OSR-1:0][DEN_W-1:0]                      den,
    input  logic [NUM_OSR-1:0]                                 sat,
    input  logic [CLK_W-1:0]                                   clock,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [NUM_OSR-1:0][$clog2(MAX_DIVISOR+1)-1:0]       dvr,
    output logic [NUM_OSR-1:0][$clog2(MAX_DIVISOR+1)+DEN_W-1:0] err
);

    localparam int QW = $clog2(MAX_DIVISOR + 1);
    localparam int PW = QW + DEN_W;
    localparam logic [QW-1:0] DMAX = QW'(MAX_DIVISOR);
    localparam logic [QW-1:0] DONE = QW'(1);

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       rdy1;
    logic                       rdy2;
    logic [NUM_OSR-1:0][QW-1:0] d1_reg;
    logic [NUM_OSR-1:0][QW-1:0] d1_next;
    logic [NUM_OSR-1:0][PW-1:0] prod_reg;
    logic [NUM_OSR-1:0][PW-1:0] prod_next;
    logic [NUM_OSR-1:0][QW-1:0] d2_reg;
    logic [NUM_OSR-1:0][PW-1:0] err_reg;
    logic [NUM_OSR-1:0][PW-1:0] err_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Clamp to 1..MAX and form divisor * osr * baud
    always_comb
    begin
        for (int k = 0; k < NUM_OSR; k++)
        begin
            if (sat[k])
            begin
                d1_next[k] = DMAX;
            end
            else if (q[k] == '0)
            begin
                d1_next[k] = DONE;
            end
            else
            begin
                d1_next[k] = q[k];
            end
            prod_next[k] = PW'(d1_next[k]) * PW'(den[k]);
        end
    end

    // Absolute distance from the clock
    always_comb
    begin
        for (int k = 0; k < NUM_OSR; k++)
        begin
            if (prod_reg[k] >= PW'(clock))
            begin
                err_next[k] = prod_reg[k] - PW'(clock);
            end
            else
            begin
                err_next[k] = PW'(clock) - prod_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            d1_reg   <= d1_next;
            prod_reg <= prod_next;
        end
        if (v1_reg && rdy2)
        begin
            d2_reg  <= d1_reg;
            err_reg <= err_next;
        end
    end

    assign out_valid = v2_reg;
    assign dvr       = d2_reg;
    assign err       = err_reg;

endmodule

FILE: hdl/ubds_min.sv
module ubds_min
    import ubds_pkg::*;
#(
    parameter int N_IN = 2,
    parameter int QW   = 13,
    parameter int PW   = 41
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [N_IN-1:0][PW-1:0]           err_in,
    input  logic [N_IN-1:0][QW-1:0]           d_in,
    input  logic [N_IN-1:0][OSR_W-1:0]        osr_in,
    input  logic [N_IN-1:0]                   ok_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [N_IN/2-1:0][PW-1:0]         err_out,
    output logic [N_IN/2-1:0][QW-1:0]         d_out,
    output logic [N_IN/2-1:0][OSR_W-1:0]      osr_out,
    output logic [N_IN/2-1:0]                 ok_out
);

    localparam int NO = N_IN / 2;

    logic                       valid_reg;
    logic [NO-1:0][PW-1:0]      err_reg;
    logic [NO-1:0][PW-1:0]      err_next;
    logic [NO-1:0][QW-1:0]      d_reg;
    logic [NO-1:0][QW-1:0]      d_next;
    logic [NO-1:0][OSR_W-1:0]   osr_reg;
    logic [NO-1:0][OSR_W-1:0]   osr_next;
    logic [NO-1:0]              ok_reg;
    logic [NO-1:0]              ok_next;

    assign in_ready = !valid_reg || out_ready;

    // Pairwise pick; upper (larger ratio) wins ties
    always_comb
    begin
        logic take_hi;
        for (int k = 0; k < NO; k++)
        begin
            take_hi = ok_in[2*k+1] &&
                      (!ok_in[2*k] || (err_in[2*k+1] <= err_in[2*k]));
            err_next[k] = take_hi ? err_in[2*k+1] : err_in[2*k];
            d_next[k]   = take_hi ? d_in[2*k+1]   : d_in[2*k];
            osr_next[k] = take_hi ? osr_in[2*k+1] : osr_in[2*k];
            ok_next[k]  = ok_in[2*k] || ok_in[2*k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            err_reg <= err_next;
            d_reg   <= d_next;
            osr_reg <= osr_next;
            ok_reg  <= ok_next;
        end
    end

    assign out_valid = valid_reg;
    assign err_out   = err_reg;
    assign d_out     = d_reg;
    assign osr_out   = osr_reg;
    assign ok_out    = ok_reg;

endmodule

FILE: hdl/uart_baud_divisor_search.sv
// Pipeline: 2 setup stages, one restoring division stage per quotient bit,
//   2 error stages and a 5-level registered minimum tree over the 29 ratio lanes.
// Throughput: one word per cycle while out_ready is high, a low out_ready stalls it;
//   all 29 ratios run side by side in lanes.
// Reset: asynchronous, active low; empties the pipeline, clock register to 24000000.
module uart_baud_divisor_search
    import ubds_pkg::*;
#(
    parameter int MAX_DIVISOR = 8191,
    localparam int DIV_W      = $clog2(MAX_DIVISOR + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              reference_clock_hz_we,
    input  logic [CLK_W-1:0]  reference_clock_hz,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BAUD_W-1:0] baud_rate,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OSR_W-1:0]  best_oversample,
    output logic [DIV_W-1:0]  best_divisor,
    output logic [ERR_W-1:0]  abs_error
);

    localparam int QW = DIV_W;
    localparam int PW = QW + DEN_W;
    localparam int CW = (PW > ERR_W) ? PW : ERR_W;

    logic [CLK_W-1:0] clock_reg;

    // Divider chain signals, index 0 is setup output
    logic [QW:0]                             dv_valid;
    logic [QW:0]                             dv_ready;
    logic [QW:0][NUM_OSR-1:0][NUM_W-1:0]     dv_rem;
    logic [QW:0][NUM_OSR-1:0][NUM_W-1:0]     dv_dvs;
    logic [QW:0][NUM_OSR-1:0][DEN_W-1:0]     dv_den;
    logic [QW:0][NUM_OSR-1:0]                dv_sat;
    logic [QW:0][NUM_OSR-1:0][QW-1:0]        dv_q;

    logic                                    e_valid;
    logic                                    e_ready;
    logic [NUM_OSR-1:0][QW-1:0]              e_d;
    logic [NUM_OSR-1:0][PW-1:0]              e_err;

    logic [TREE_N-1:0][PW-1:0]               t32_err;
    logic [TREE_N-1:0][QW-1:0]               t32_d;
    logic [TREE_N-1:0][OSR_W-1:0]            t32_osr;
    logic [TREE_N-1:0]                       t32_ok;
    logic [15:0][PW-1:0]                     t16_err;
    logic [15:0][QW-1:0]                     t16_d;
    logic [15:0][OSR_W-1:0]                  t16_osr;
    logic [15:0]                             t16_ok;
    logic [7:0][PW-1:0]                      t8_err;
    logic [7:0][QW-1:0]                      t8_d;
    logic [7:0][OSR_W-1:0]                   t8_osr;
    logic [7:0]                              t8_ok;
    logic [3:0][PW-1:0]                      t4_err;
    logic [3:0][QW-1:0]                      t4_d;
    logic [3:0][OSR_W-1:0]                   t4_osr;
    logic [3:0]                              t4_ok;
    logic [1:0][PW-1:0]                      t2_err;
    logic [1:0][QW-1:0]                      t2_d;
    logic [1:0][OSR_W-1:0]                   t2_osr;
    logic [1:0]                              t2_ok;
    logic [0:0][PW-1:0]                      t1_err;
    logic [0:0][QW-1:0]                      t1_d;
    logic [0:0][OSR_W-1:0]                   t1_osr;
    logic [0:0]                              t1_ok;
    logic [3:0]                              tv;
    logic [3:0]                              tr;
    logic                                    t16_ready;
    logic [CW-1:0]                           err_ext;

    // Clock frequency register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= CLOCK_RESET;
        end
        else if (reference_clock_hz_we)
        begin
            clock_reg <= reference_clock_hz;
        end
    end

    // Setup stages
    ubds_prep #(.MAX_DIVISOR(MAX_DIVISOR)) u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .baud      (baud_rate),
        .clock     (clock_reg),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .rem       (dv_rem[0]),
        .dvs       (dv_dvs[0]),
        .den       (dv_den[0]),
        .sat       (dv_sat[0])
    );

    assign dv_q[0] = '0;

    // One division stage per quotient bit, MSB first
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        ubds_div_step #(.MAX_DIVISOR(MAX_DIVISOR), .BIT(QW - 1 - j)) u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .rem_in    (dv_rem[j]),
            .dvs_in    (dv_dvs[j]),
            .den_in    (dv_den[j]),
            .sat_in    (dv_sat[j]),
            .q_in      (dv_q[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .rem_out   (dv_rem[j+1]),
            .dvs_out   (dv_dvs[j+1]),
            .den_out   (dv_den[j+1]),
            .sat_out   (dv_sat[j+1]),
            .q_out     (dv_q[j+1])
        );
    end

    // Clamp, product and error
    ubds_err #(.MAX_DIVISOR(MAX_DIVISOR)) u_err
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[QW]),
        .in_ready  (dv_ready[QW]),
        .q         (dv_q[QW]),
        .den       (dv_den[QW]),
        .sat       (dv_sat[QW]),
        .clock     (clock_reg),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .dvr       (e_d),
        .err       (e_err)
    );

    // Tree leaves; spare lanes never win
    always_comb
    begin
        for (int k = 0; k < TREE_N; k++)
        begin
            if (k < NUM_OSR)
            begin
                t32_err[k] = e_err[k];
                t32_d[k]   = e_d[k];
                t32_osr[k] = osr_of(k);
                t32_ok[k]  = 1'b1;
            end
            else
            begin
                t32_err[k] = '0;
                t32_d[k]   = '0;
                t32_osr[k] = '0;
                t32_ok[k]  = 1'b0;
            end
        end
    end

    ubds_min #(.N_IN(32), .QW(QW), .PW(PW)) u_min32
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(e_valid), .in_ready(e_ready),
        .err_in(t32_err), .d_in(t32_d), .osr_in(t32_osr), .ok_in(t32_ok),
        .out_valid(tv[0]), .out_ready(t16_ready),
        .err_out(t16_err), .d_out(t16_d), .osr_out(t16_osr), .ok_out(t16_ok)
    );

    ubds_min #(.N_IN(16), .QW(QW), .PW(PW)) u_min16
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(tv[0]), .in_ready(t16_ready),
        .err_in(t16_err), .d_in(t16_d), .osr_in(t16_osr), .ok_in(t16_ok),
        .out_valid(tv[1]), .out_ready(tr[1]),
        .err_out(t8_err), .d_out(t8_d), .osr_out(t8_osr), .ok_out(t8_ok)
    );

    ubds_min #(.N_IN(8), .QW(QW), .PW(PW)) u_min8
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(tv[1]), .in_ready(tr[1]),
        .err_in(t8_err), .d_in(t8_d), .osr_in(t8_osr), .ok_in(t8_ok),
        .out_valid(tv[2]), .out_ready(tr[2]),
        .err_out(t4_err), .d_out(t4_d), .osr_out(t4_osr), .ok_out(t4_ok)
    );

    ubds_min #(.N_IN(4), .QW(QW), .PW(PW)) u_min4
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(tv[2]), .in_ready(tr[2]),
        .err_in(t4_err), .d_in(t4_d), .osr_in(t4_osr), .ok_in(t4_ok),
        .out_valid(tv[3]), .out_ready(tr[3]),
        .err_out(t2_err), .d_out(t2_d), .osr_out(t2_osr), .ok_out(t2_ok)
    );

    ubds_min #(.N_IN(2), .QW(QW), .PW(PW)) u_min2
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(tv[3]), .in_ready(tr[3]),
        .err_in(t2_err), .d_in(t2_d), .osr_in(t2_osr), .ok_in(t2_ok),
        .out_valid(out_valid), .out_ready(out_ready),
        .err_out(t1_err), .d_out(t1_d), .osr_out(t1_osr), .ok_out(t1_ok)
    );

    assign tr[0] = t16_ready;

    // Result word, error saturated to the field width
    assign err_ext         = CW'(t1_err[0]);
    assign best_oversample = t1_osr[0];
    assign best_divisor    = t1_d[0];
    assign abs_error       = (err_ext > CW'(ERR_MAX)) ? ERR_MAX : err_ext[ERR_W-1:0];

`ifndef SYNTHESIS
    // Winner always comes from a real ratio lane
    a_winner_real: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> t1_ok[0] && tv[0] == tv[0])
        else $error("result word without a real ratio lane");

    a_osr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_oversample >= OSR_W'(OSR_MIN)) &&
                      (best_oversample <= OSR_W'(OSR_MAX)))
        else $error("oversampling ratio out of range");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_divisor != '0) && (best_divisor <= DIV_W'(MAX_DIVISOR)))
        else $error("divisor out of clamp range");

    // A drained sink must open the whole stall chain
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready && tr[0])
        else $error("stall chain blocked while sink is ready");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ubds_pkg::*;

    localparam int MAX_DIV    = 8191;
    localparam int DIV_W      = 13;
    localparam int LATENCY    = 22;
    localparam int N_RANDOM   = 1650;
    localparam int WATCHDOG   = 20000;
    localparam int HOLD_OFF   = 300;
    localparam int N_DIRECTED = 14;

    typedef struct packed {
        logic [OSR_W-1:0] osr;
        logic [DIV_W-1:0] div;
        logic [ERR_W-1:0] err;
    } search_result_t;

    // Directed row: clock setting (written first when load is set), baud, optional expected
    typedef struct {
        bit               load;
        logic [CLK_W-1:0] clk_hz;
        logic [BAUD_W-1:0] baud;
        bit               known;
        search_result_t   res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic clk_we = 1'b0;
    logic [CLK_W-1:0] clk_hz_wr = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [BAUD_W-1:0] baud_rate = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OSR_W-1:0] best_oversample;
    logic [DIV_W-1:0] best_divisor;
    logic [ERR_W-1:0] abs_error;

    logic [CLK_W-1:0] model_clock_hz = CLOCK_RESET;
    search_result_t expected_words[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off_req = 1'b0;
    bit calm_out = 1'b0;
    bit stim_done = 1'b0;
    row_t rows[N_DIRECTED];

    always #2 clk = ~clk;

    uart_baud_divisor_search i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .reference_clock_hz_we(clk_we),
        .reference_clock_hz(clk_hz_wr),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .baud_rate(baud_rate),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .best_oversample(best_oversample),
        .best_divisor(best_divisor),
        .abs_error(abs_error)
    );

    // Exact search over all ratios; ties go to the larger ratio
    function automatic search_result_t best_divisor_for(logic [CLK_W-1:0] hz,
                                                        logic [BAUD_W-1:0] baud);
        search_result_t r;
        logic [63:0] best_e;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] prod;
        logic [63:0] e;
        best_e = '1;
        r = '0;
        for (int osr = OSR_MIN; osr <= OSR_MAX; osr++) begin
            if (baud == 0)
                q = MAX_DIV;
            else begin
                den = 64'(baud) * osr;
                q = (2 * 64'(hz) + den) / (2 * den);
                if (q < 1)
                    q = 1;
                else if (q > MAX_DIV)
                    q = MAX_DIV;
            end
            prod = q * osr * 64'(baud);
            e = (prod >= hz) ? prod - hz : 64'(hz) - prod;
            if (e <= best_e) begin
                best_e = e;
                r.osr = OSR_W'(osr);
                r.div = DIV_W'(q);
            end
        end
        r.err = (best_e > 64'(ERR_MAX)) ? ERR_MAX : best_e[ERR_W-1:0];
        return r;
    endfunction

    task automatic write_clock(logic [CLK_W-1:0] hz);
        clk_we <= 1'b1;
        clk_hz_wr <= hz;
        @(posedge clk);
        clk_we <= 1'b0;
        model_clock_hz = hz;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Offer one word and hold it until accepted
    task automatic send_baud(logic [BAUD_W-1:0] b, bit gaps);
        while (gaps && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        baud_rate <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_words.push_back(best_divisor_for(model_clock_hz, b));
    endtask

    function automatic logic [BAUD_W-1:0] random_baud();
        case ($urandom_range(5))
            0: return BAUD_W'($urandom);
            1: return BAUD_W'($urandom_range(8000000, 1));
            2: return BAUD_W'($urandom_range(4000, 1));
            3: return BAUD_W'($urandom_range(921600, 300));
            4: return BAUD_W'($urandom_range(3));
            default: return BAUD_W'($urandom_range(8388607, 8000000));
        endcase
    endfunction

    function automatic row_t mk(bit load, logic [CLK_W-1:0] hz, logic [BAUD_W-1:0] b,
                                bit known, search_result_t r);
        row_t x;
        x.load = load;
        x.clk_hz = hz;
        x.baud = b;
        x.known = known;
        x.res = r;
        return x;
    endfunction

    // Stimulus
    initial begin
        logic [CLK_W-1:0] hz;
        rows[0]  = mk(0, 0, 23'd0, 1, '{6'd32, 13'd8191, 42'd24000000});
        rows[1]  = mk(0, 0, 23'd115200, 0, '0);
        rows[2]  = mk(0, 0, 23'd8388607, 0, '0);
        rows[3]  = mk(0, 0, 23'd1, 0, '0);
        rows[4]  = mk(0, 0, 23'd8000000, 0, '0);
        rows[5]  = mk(1, 27'd0, 23'd1000, 1, '{6'd4, 13'd1, 42'd4000});
        rows[6]  = mk(0, 0, 23'd0, 1, '{6'd32, 13'd8191, 42'd0});
        rows[7]  = mk(1, 27'd134217727, 23'd8388607, 0, '0);
        rows[8]  = mk(0, 0, 23'd1, 0, '0);
        rows[9]  = mk(0, 0, 23'd0, 1, '{6'd32, 13'd8191, 42'd134217727});
        rows[10] = mk(1, 27'd1000000, 23'd1, 0, '0);
        rows[11] = mk(0, 0, 23'd5592405, 0, '0);
        rows[12] = mk(1, 27'd100000000, 23'd3000000, 0, '0);
        rows[13] = mk(0, 0, 23'd2796202, 0, '0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (rows[i].load) begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait_drained();
                write_clock(rows[i].clk_hz);
            end
            send_baud(rows[i].baud, 1'b0);
            if (rows[i].known && expected_words[$] !== rows[i].res) begin
                $display("%0t table row %0d: expected %p, predicted %p", $time, i,
                         rows[i].res, expected_words[$]);
                errors++;
            end
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            // new clock setting now and then, sender waits for all results first
            if (i % 300 == 150) begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait_drained();
                case ($urandom_range(3))
                    0: hz = 27'd1000000;
                    1: hz = 27'd100000000;
                    2: hz = 27'($urandom);
                    default: hz = 27'($urandom_range(100000000, 1000000));
                endcase
                write_clock(hz);
            end
            if (i == 400)
                hold_off_req = 1'b1;
            calm_out = (i >= 800 && i < 1000);
            send_baud(random_baud(), !(i >= 800 && i < 1000));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off
    initial begin
        int held;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF; held++)
                    @(posedge clk);
            end
            out_ready <= calm_out || ($urandom_range(99) >= 17);
        end
    end

    // Result checking
    always @(posedge clk) begin
        search_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: osr %0d div %0d err %0d", $time,
                         best_oversample, best_divisor, abs_error);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (best_oversample !== want.osr) begin
                    $display("%0t best_oversample: expected %0d, actual %0d", $time,
                             want.osr, best_oversample);
                    errors++;
                end
                if (best_divisor !== want.div) begin
                    $display("%0t best_divisor: expected %0d, actual %0d", $time,
                             want.div, best_divisor);
                    errors++;
                end
                if (abs_error !== want.err) begin
                    $display("%0t abs_error: expected %0d, actual %0d", $time,
                             want.err, abs_error);
                    errors++;
                end
            end
        end
    end

    // Watchdog and end of run
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("DONE: errors detected");
                $finish;
            end
            if (stim_done && expected_words.size() == 0) begin
                repeat (LATENCY + 8) @(posedge clk);
                if (errors == 0 && expected_words.size() == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

FILE: uart_baud_divisor_search.f
hdl/ubds_pkg.sv
hdl/ubds_prep.sv
hdl/ubds_div_step.sv
hdl/ubds_err.sv
hdl/ubds_min.sv
hdl/uart_baud_divisor_search.sv
bench/testbench.sv
